FILE: rtl/vse_pkg.sv
// Shared types, constants and helpers for the volume slice extractor.
`default_nettype none

package vse_pkg;

  // Lattice geometry
  localparam int MAX_DIM = 64;
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int SIZE_W  = 7;
  localparam int POS_W   = 6;

  // Payload widths
  localparam int VEL_W   = 16;
  localparam int DENS_W  = 16;
  localparam int PIX_W   = 17;
  localparam int IDX_W   = 12;

  // Magnitude unit
  localparam int RAD_W   = 2 * VEL_W;
  localparam int ROOT_W  = VEL_W;
  localparam int REM_W   = ROOT_W + 4;
  localparam int STEP_W  = $clog2(ROOT_W);

  // Pending-pixel queue
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Configuration port
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef enum logic [2:0] {
    REG_ORIENT = 3'd0,
    REG_FIELD  = 3'd1,
    REG_SLICE  = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ORIENT_XY = 2'd0,
    ORIENT_XZ = 2'd1,
    ORIENT_YZ = 2'd2
  } orient_e;

  typedef enum logic [2:0] {
    FIELD_MAG   = 3'd0,
    FIELD_VX    = 3'd1,
    FIELD_VY    = 3'd2,
    FIELD_VZ    = 3'd3,
    FIELD_DENS  = 3'd4,
    FIELD_SOLID = 3'd5
  } field_e;

  typedef enum logic [3:0] {
    BK_IDLE   = 4'b0001,
    BK_SQUARE = 4'b0010,
    BK_SUM    = 4'b0100,
    BK_ROOT   = 4'b1000
  } back_state_e;

  typedef struct packed {
    logic [1:0]        orientation;
    logic [2:0]        field_select;
    logic [POS_W-1:0]  slice_position;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } cfg_t;

  // One classified pixel waiting for the back end
  typedef struct packed {
    logic                    is_mag;
    logic signed [PIX_W-1:0] value;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } entry_t;

  // Zero counts as one, anything above the lattice limit saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vse_in_if.sv
// Voxel input channel: valid/ready with the voxel payload.
`default_nettype none

interface vse_in_if
  import vse_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic [DENS_W-1:0]       cell_density;
  logic                    solid_flag;

  modport source (output valid, vel_x, vel_y, vel_z, cell_density, solid_flag,
                  input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, cell_density, solid_flag,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/vse_out_if.sv
// Pixel output channel: valid/ready with the pixel payload.
`default_nettype none

interface vse_out_if
  import vse_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_value;
  logic [IDX_W-1:0]        pixel_index;
  logic                    slice_last;

  modport source (output valid, pixel_value, pixel_index, slice_last,
                  input ready);
  modport sink   (input valid, pixel_value, pixel_index, slice_last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/volume_slice_extractor_top.sv
// Top level: configuration registers, front end, pixel queue and back end.
`default_nettype none

// Volume slice extractor. Voxels arrive in raster order (x fastest, then y,
// then z) on vox_i; each voxel lying on the configured XY, XZ or YZ plane
// yields one pixel on pix_o with its raster index in the slice and a last
// flag on the final pixel. The input takes one voxel per cycle as long as
// the four-entry pixel queue has room. Pixels that carry a component,
// density or obstacle flag leave at one per cycle while the output is not
// stalled. A magnitude pixel holds the back end while it is taken from the
// queue, squared, summed and run through the bit-serial square root; no new
// pixel leaves the queue until the root is done. There is no clearing pass
// after reset. Program the APB registers only while idle.
module volume_slice_extractor_top
  import vse_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel_i,
  input  wire logic              penable_i,
  input  wire logic              pwrite_i,
  input  wire logic [ADDR_W-1:0] paddr_i,
  input  wire logic [DATA_W-1:0] pwdata_i,
  output logic      [DATA_W-1:0] prdata_o,
  output logic                   pready_o,
  vse_in_if.sink                 vox_i,
  vse_out_if.source              pix_o
);

  cfg_t               cfg_q;
  logic               cfg_wr;
  reg_idx_e           reg_sel;
  logic               push, pop, q_empty, q_full, back_busy;
  entry_t             push_entry, head_entry;
  logic [QCNT_W-1:0]  q_count;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign reg_sel  = reg_idx_e'(paddr_i[ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation    <= ORIENT_XY;
      cfg_q.field_select   <= FIELD_MAG;
      cfg_q.slice_position <= '0;
      cfg_q.size_x         <= SIZE_W'(MAX_DIM);
      cfg_q.size_y         <= SIZE_W'(MAX_DIM);
      cfg_q.size_z         <= SIZE_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ORIENT: cfg_q.orientation    <= pwdata_i[1:0];
        REG_FIELD:  cfg_q.field_select   <= pwdata_i[2:0];
        REG_SLICE:  cfg_q.slice_position <= pwdata_i[POS_W-1:0];
        REG_SIZE_X: cfg_q.size_x         <= pwdata_i[SIZE_W-1:0];
        REG_SIZE_Y: cfg_q.size_y         <= pwdata_i[SIZE_W-1:0];
        REG_SIZE_Z: cfg_q.size_z         <= pwdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_sel)
      REG_ORIENT: prdata_o = DATA_W'(cfg_q.orientation);
      REG_FIELD:  prdata_o = DATA_W'(cfg_q.field_select);
      REG_SLICE:  prdata_o = DATA_W'(cfg_q.slice_position);
      REG_SIZE_X: prdata_o = DATA_W'(cfg_q.size_x);
      REG_SIZE_Y: prdata_o = DATA_W'(cfg_q.size_y);
      REG_SIZE_Z: prdata_o = DATA_W'(cfg_q.size_z);
      default:    prdata_o = '0;
    endcase
  end

  vse_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .vox_i   (vox_i),
    .full_i  (q_full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  vse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full),
    .count_o (q_count)
  );

  vse_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_entry),
    .empty_i (q_empty),
    .pop_o   (pop),
    .busy_o  (back_busy),
    .pix_o   (pix_o)
  );

  // Checks
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCNT_W'(QDEPTH))
    else $error("pixel queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty pixel queue");

  a_busy_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_busy && $past(back_busy)) |-> !pix_o.valid)
    else $error("output valid while magnitude in progress");

endmodule

`default_nettype wire

FILE: rtl/vse_front.sv
// Front end: tracks voxel coordinates, picks out slice voxels, builds queue entries.
`default_nettype none

module vse_front
  import vse_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  vse_in_if.sink      vox_i,
  input  wire logic   full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic [COORD_W-1:0] x_q, y_q, z_q;
  logic [COORD_W-1:0] x_d, y_d, z_d;
  logic [SIZE_W-1:0]  sx, sy, sz;
  logic               accept;
  logic               emit;
  logic [COORD_W-1:0] a_crd, b_crd, n_crd;
  logic [SIZE_W-1:0]  a_size, b_size, n_size;
  logic [SIZE_W+COORD_W:0] idx_full;
  logic [SIZE_W-1:0]  x_inc, y_inc, z_inc;

  assign sx = eff_size(cfg_i.size_x);
  assign sy = eff_size(cfg_i.size_y);
  assign sz = eff_size(cfg_i.size_z);

  assign vox_i.ready = !full_i;
  assign accept      = vox_i.valid && vox_i.ready;

  // Plane select: in-plane coordinates a (fast), b (slow), normal n
  always_comb begin
    unique case (cfg_i.orientation)
      ORIENT_XY: begin
        a_crd = x_q; a_size = sx;
        b_crd = y_q; b_size = sy;
        n_crd = z_q; n_size = sz;
      end
      ORIENT_YZ: begin
        a_crd = y_q; a_size = sy;
        b_crd = z_q; b_size = sz;
        n_crd = x_q; n_size = sx;
      end
      default: begin
        a_crd = x_q; a_size = sx;
        b_crd = z_q; b_size = sz;
        n_crd = y_q; n_size = sy;
      end
    endcase
  end

  assign emit = (SIZE_W'(cfg_i.slice_position) < n_size) &&
                (n_crd == COORD_W'(cfg_i.slice_position));

  assign idx_full = (SIZE_W+COORD_W+1)'(a_crd) +
                    (SIZE_W+COORD_W+1)'(a_size) * (SIZE_W+COORD_W+1)'(b_crd);

  // Entry build, with the non-magnitude value already selected
  always_comb begin
    entry_o.is_mag = (cfg_i.field_select == FIELD_MAG);
    entry_o.vel_x  = vox_i.vel_x;
    entry_o.vel_y  = vox_i.vel_y;
    entry_o.vel_z  = vox_i.vel_z;
    entry_o.idx    = idx_full[IDX_W-1:0];
    entry_o.last   = (SIZE_W'(a_crd) + SIZE_W'(1) == a_size) &&
                     (SIZE_W'(b_crd) + SIZE_W'(1) == b_size);
    unique case (cfg_i.field_select)
      FIELD_VX:    entry_o.value = PIX_W'(vox_i.vel_x);
      FIELD_VY:    entry_o.value = PIX_W'(vox_i.vel_y);
      FIELD_VZ:    entry_o.value = PIX_W'(vox_i.vel_z);
      FIELD_DENS:  entry_o.value = $signed({1'b0, vox_i.cell_density});
      FIELD_SOLID: entry_o.value = $signed(PIX_W'(vox_i.solid_flag));
      default:     entry_o.value = '0;
    endcase
  end

  assign push_o = accept && emit;

  // Raster counters, wrap test is coordinate + 1 >= extent
  assign x_inc = SIZE_W'(x_q) + SIZE_W'(1);
  assign y_inc = SIZE_W'(y_q) + SIZE_W'(1);
  assign z_inc = SIZE_W'(z_q) + SIZE_W'(1);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (accept) begin
      if (x_inc >= sx) begin
        x_d = '0;
        if (y_inc >= sy) begin
          y_d = '0;
          if (z_inc >= sz) begin
            z_d = '0;
          end else begin
            z_d = z_inc[COORD_W-1:0];
          end
        end else begin
          y_d = y_inc[COORD_W-1:0];
        end
      end else begin
        x_d = x_inc[COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vse_queue.sv
// Small register FIFO of pending pixels between front and back ends.
`default_nettype none

module vse_queue
  import vse_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output logic        empty_o,
  output logic        full_o,
  output logic [QCNT_W-1:0] count_o
);

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign count_o = cnt_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/vse_back.sv
// Back end: magnitude root unit and the registered pixel output.
`default_nettype none

module vse_back
  import vse_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire entry_t head_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output logic        busy_o,
  vse_out_if.source   pix_o
);

  back_state_e             state_q, state_d;
  logic signed [VEL_W-1:0] vx_q, vy_q, vz_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    last_q;
  logic [RAD_W-1:0]        sqx_q, sqy_q, sqz_q;
  logic [RAD_W-1:0]        rad_q;
  logic [REM_W-1:0]        rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]       root_q, root_d;
  logic [STEP_W-1:0]       step_q;
  logic                    out_free;
  logic                    root_done;

  logic                    ovalid_q;
  logic signed [PIX_W-1:0] oval_q;
  logic [IDX_W-1:0]        oidx_q;
  logic                    olast_q;

  assign out_free  = !ovalid_q || pix_o.ready;
  assign pop_o     = (state_q == BK_IDLE) && !empty_i && out_free;
  assign busy_o    = (state_q != BK_IDLE);
  assign root_done = (state_q == BK_ROOT) && (step_q == STEP_W'(ROOT_W - 1));

  assign pix_o.valid       = ovalid_q;
  assign pix_o.pixel_value = oval_q;
  assign pix_o.pixel_index = oidx_q;
  assign pix_o.slice_last  = olast_q;

  // One root bit per cycle: bring down two radicand bits, trial subtract
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});

  always_comb begin
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:   if (pop_o && head_i.is_mag) state_d = BK_SQUARE;
      BK_SQUARE: state_d = BK_SUM;
      BK_SUM:    state_d = BK_ROOT;
      BK_ROOT:   if (root_done) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((pop_o && !head_i.is_mag) || root_done) begin
        ovalid_q <= 1'b1;
      end else if (pix_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      vx_q   <= head_i.vel_x;
      vy_q   <= head_i.vel_y;
      vz_q   <= head_i.vel_z;
      idx_q  <= head_i.idx;
      last_q <= head_i.last;
    end
    if (state_q == BK_SQUARE) begin
      sqx_q <= RAD_W'(vx_q) * RAD_W'(vx_q);
      sqy_q <= RAD_W'(vy_q) * RAD_W'(vy_q);
      sqz_q <= RAD_W'(vz_q) * RAD_W'(vz_q);
    end
    if (state_q == BK_SUM) begin
      rad_q  <= sqx_q + sqy_q + sqz_q;
      rem_q  <= '0;
      root_q <= '0;
      step_q <= '0;
    end
    if (state_q == BK_ROOT) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
      step_q <= step_q + STEP_W'(1);
    end
    // Output register
    if (pop_o && !head_i.is_mag) begin
      oval_q  <= head_i.value;
      oidx_q  <= head_i.idx;
      olast_q <= head_i.last;
    end else if (root_done) begin
      oval_q  <= $signed(PIX_W'(root_d));
      oidx_q  <= idx_q;
      olast_q <= last_q;
    end
  end

endmodule

`default_nettype wire
